// ===== rtl/core/mrfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_pkg
// Shared types, constants and the CRC-16 byte update for the RTU receiver.
// ----------------------------------------------------------------------------
package mrfr_pkg;

  localparam int BUF_DEPTH = 256;

  localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
  localparam logic [7:0]  FC_READ_INPUT = 8'h04;
  localparam logic [7:0]  FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULT = 8'h10;

  localparam logic [8:0]  WRITE_ONE_LEN = 9'd6;
  localparam logic [8:0]  WRITE_HDR_LEN = 9'd5;
  localparam logic [8:0]  CRC_BYTES     = 9'd2;
  localparam logic [8:0]  COUNT_MAX     = 9'h1FF;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic [7:0]  ADDR_RESET    = 8'd1;
  localparam logic [7:0]  READ_LEN_RESET = 8'd29;

  localparam logic REG_EXP_ADDR = 1'b0;
  localparam logic REG_READ_LEN = 1'b1;

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_CODE = 2'd1,
    PH_BODY = 2'd2,
    PH_HDR  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] expected_address;
    logic [7:0] read_reply_len;
  } cfg_t;

  typedef struct packed {
    logic       byte_accepted;
    logic [8:0] byte_index;
    logic [7:0] byte_value;
    logic       buffer_overflow;
    logic       frame_abort;
    logic       frame_done;
    logic       crc_ok;
    logic [7:0] function_code;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mrfr_byte_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_byte_if
// Received byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mrfr_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_res_if
// Per-byte framing result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrfr_res_if;
  logic       valid;
  logic       ready;
  logic       byte_accepted;
  logic [8:0] byte_index;
  logic [7:0] byte_value;
  logic       buffer_overflow;
  logic       frame_abort;
  logic       frame_done;
  logic       crc_ok;
  logic [7:0] function_code;

  modport source (
    output valid, output byte_accepted, output byte_index, output byte_value,
    output buffer_overflow, output frame_abort, output frame_done, output crc_ok,
    output function_code, input ready
  );
  modport sink (
    input valid, input byte_accepted, input byte_index, input byte_value,
    input buffer_overflow, input frame_abort, input frame_done, input crc_ok,
    input function_code, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/mrfr_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_cfg_regs
// APB register file: expected slave address and read reply length.
// ----------------------------------------------------------------------------
module mrfr_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mrfr_pkg::cfg_t    cfg
);
  import mrfr_pkg::*;

  logic       wr_en;
  logic [7:0] expected_address;
  logic [7:0] read_reply_len;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= ADDR_RESET;
      read_reply_len   <= READ_LEN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_EXP_ADDR: expected_address <= pwdata[7:0];
        REG_READ_LEN: read_reply_len   <= pwdata[7:0];
        default:      expected_address <= expected_address;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXP_ADDR: prdata = {24'h000000, expected_address};
      REG_READ_LEN: prdata = {24'h000000, read_reply_len};
      default:      prdata = 32'h0;
    endcase
  end

  assign cfg.expected_address = expected_address;
  assign cfg.read_reply_len   = read_reply_len;
endmodule
`default_nettype wire

// ===== rtl/core/mrfr_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_in_stage
// Input register for received bytes, refilled in the cycle it drains.
// ----------------------------------------------------------------------------
module mrfr_in_stage (
  input  wire logic   clk,
  input  wire logic   rst,
  mrfr_byte_if.sink   rx,
  input  wire logic   take,
  output logic        byte_valid,
  output logic [7:0]  byte_data
);
  import mrfr_pkg::*;

  assign rx.ready = !byte_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      byte_data <= rx.rx_byte;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mrfr_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_framer
// Frame tracking, CRC accumulation and the registered result stage.
// ----------------------------------------------------------------------------
module mrfr_framer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mrfr_pkg::cfg_t cfg,
  input  wire logic           byte_valid,
  input  wire logic [7:0]     byte_data,
  output logic                take,
  mrfr_res_if.source          res
);
  import mrfr_pkg::*;

  phase_t      phase, phase_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [8:0]  frame_count, frame_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  current_code, current_code_next;

  logic        res_valid;
  res_t        res_q, res_next;

  logic        acc, abort_f, done;
  logic [8:0]  idx;
  logic [15:0] crc_base, crc_new;

  assign take = byte_valid && (!res_valid || res.ready);

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    current_code_next = current_code;
    acc               = 1'b0;
    abort_f           = 1'b0;
    done              = 1'b0;
    unique case (phase)
      PH_ADDR: begin
        if (byte_data == cfg.expected_address) begin
          acc               = 1'b1;
          current_code_next = 8'h00;
          phase_next        = PH_CODE;
        end
      end
      PH_CODE: begin
        current_code_next = byte_data;
        if (byte_data == FC_READ_HOLD || byte_data == FC_READ_INPUT) begin
          acc             = 1'b1;
          bytes_left_next = {1'b0, cfg.read_reply_len};
          phase_next      = PH_BODY;
        end else if (byte_data == FC_WRITE_ONE) begin
          acc             = 1'b1;
          bytes_left_next = WRITE_ONE_LEN;
          phase_next      = PH_BODY;
        end else if (byte_data == FC_WRITE_MULT) begin
          acc             = 1'b1;
          bytes_left_next = WRITE_HDR_LEN;
          phase_next      = PH_HDR;
        end else begin
          abort_f    = 1'b1;
          phase_next = PH_ADDR;
        end
      end
      PH_BODY: begin
        acc = 1'b1;
        if (bytes_left <= 9'd1) begin
          bytes_left_next = 9'd0;
          done            = 1'b1;
          phase_next      = PH_ADDR;
        end else begin
          bytes_left_next = bytes_left - 9'd1;
        end
      end
      PH_HDR: begin
        acc = 1'b1;
        if (bytes_left <= 9'd1) begin
          bytes_left_next = {1'b0, byte_data} + CRC_BYTES;
          phase_next      = PH_BODY;
        end else begin
          bytes_left_next = bytes_left - 9'd1;
        end
      end
      default: phase_next = PH_ADDR;
    endcase
  end

  // address byte restarts count and crc
  assign idx      = (phase == PH_ADDR) ? 9'd0 : frame_count;
  assign crc_base = (phase == PH_ADDR) ? CRC_INIT : crc_accum;
  assign crc_new  = crc_byte(crc_base, byte_data);

  always_comb begin
    frame_count_next = frame_count;
    crc_accum_next   = crc_accum;
    if (acc) begin
      frame_count_next = (idx < COUNT_MAX) ? idx + 9'd1 : idx;
      crc_accum_next   = crc_new;
    end
  end

  always_comb begin
    res_next.byte_accepted   = acc;
    res_next.byte_index      = acc ? idx : 9'd0;
    res_next.byte_value      = acc ? byte_data : 8'h00;
    res_next.buffer_overflow = acc && ({1'b0, idx} >= 10'(BUF_DEPTH));
    res_next.frame_abort     = abort_f;
    res_next.frame_done      = done;
    res_next.crc_ok          = done && (crc_new == 16'h0000);
    res_next.function_code   = current_code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ADDR;
      bytes_left   <= 9'd0;
      frame_count  <= 9'd0;
      crc_accum    <= CRC_INIT;
      current_code <= 8'h00;
      res_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        bytes_left   <= bytes_left_next;
        frame_count  <= frame_count_next;
        crc_accum    <= crc_accum_next;
        current_code <= current_code_next;
      end
      if (!res_valid || res.ready) begin
        res_valid <= byte_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_next;
    end
  end

  assign res.valid           = res_valid;
  assign res.byte_accepted   = res_q.byte_accepted;
  assign res.byte_index      = res_q.byte_index;
  assign res.byte_value      = res_q.byte_value;
  assign res.buffer_overflow = res_q.buffer_overflow;
  assign res.frame_abort     = res_q.frame_abort;
  assign res.frame_done      = res_q.frame_done;
  assign res.crc_ok          = res_q.crc_ok;
  assign res.function_code   = res_q.function_code;
endmodule
`default_nettype wire

// ===== rtl/core/modbus_rtu_frame_receiver_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_core
// Frames Modbus RTU replies from a byte stream and checks their CRC-16.
// ----------------------------------------------------------------------------
// usage:
//   rx carries one received serial byte per request; res returns one result
//   per byte: accepted flag, frame index, byte value, overflow, abort, done
//   and crc_ok on the last byte, and the current function code.
//   the apb port holds the expected slave address (0x0) and the read reply
//   length (0x4); write them only while no byte is in flight.
//   path: a taken byte is held in the input register, and its framing result
//   is then registered in res.
//   throughput: one byte per cycle while res accepts results, set by the
//   combinational crc byte update and framing step between the input and result registers.
//   reset: frame state returns to waiting for the address, the crc to
//   0xFFFF, registers to address 1 and length 29, both stages empty.
//   stall: a result not taken holds in res; one more byte waits in the input
//   register, then rx.ready drops until res drains.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_core (
  input  wire logic         clk,
  input  wire logic         rst,
  mrfr_byte_if.sink         rx,
  mrfr_res_if.source        res,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mrfr_pkg::*;

  cfg_t       cfg;
  logic       take;
  logic       byte_valid;
  logic [7:0] byte_data;

  mrfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  mrfr_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .take       (take),
    .res        (res)
  );
endmodule
`default_nettype wire

// ===== sim/modbus_rtu_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_core_tb
// Drives received bytes into the RTU frame receiver and tracks framing, byte
// indexes, overflow, aborts and the CRC-16 residue in a local frame tracker.
// Every result is checked field by field, in order. A short table of bytes
// comes first. Random frames follow under several register settings, mostly
// well formed with a correct CRC, some corrupted, truncated or noisy, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_core_tb;
  import mrfr_pkg::*;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mrfr_byte_if rx_if ();
  mrfr_res_if  res_if ();

  modbus_rtu_frame_receiver_core dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0]  exp_addr  = ADDR_RESET;
  logic [7:0]  reply_len = READ_LEN_RESET;
  phase_t      trk_phase = PH_ADDR;
  logic [8:0]  trk_left  = '0;
  logic [8:0]  trk_count = '0;
  logic [15:0] trk_crc   = CRC_INIT;
  logic [7:0]  trk_code  = '0;

  res_t byte_reports[$];
  int   mismatches   = 0;
  int   framed_items = 0;
  bit   gaps_on      = 1'b0;
  bit   quiet        = 1'b0;
  int   stall_left   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic res_t plain_result(input logic acc, input logic [8:0] idx,
                                        input logic [7:0] val, input logic abort_f,
                                        input logic [7:0] fc);
    res_t r;
    r = '0;
    r.byte_accepted = acc;
    r.byte_index    = idx;
    r.byte_value    = val;
    r.frame_abort   = abort_f;
    r.function_code = fc;
    return r;
  endfunction

  function automatic res_t frame_track(input logic [7:0] b);
    res_t r;
    logic acc;
    logic done;
    r    = '0;
    acc  = 1'b0;
    done = 1'b0;
    case (trk_phase)
      PH_ADDR: begin
        if (b == exp_addr) begin
          acc       = 1'b1;
          trk_count = '0;
          trk_crc   = CRC_INIT;
          trk_code  = '0;
          trk_phase = PH_CODE;
        end
      end
      PH_CODE: begin
        if (b == FC_READ_HOLD || b == FC_READ_INPUT) begin
          acc       = 1'b1;
          trk_left  = {1'b0, reply_len};
          trk_phase = PH_BODY;
        end else if (b == FC_WRITE_ONE) begin
          acc       = 1'b1;
          trk_left  = WRITE_ONE_LEN;
          trk_phase = PH_BODY;
        end else if (b == FC_WRITE_MULT) begin
          acc       = 1'b1;
          trk_left  = WRITE_HDR_LEN;
          trk_phase = PH_HDR;
        end else begin
          r.frame_abort = 1'b1;
          trk_phase     = PH_ADDR;
        end
        trk_code = b;
      end
      PH_BODY: begin
        acc = 1'b1;
        if (trk_left <= 9'd1) begin
          trk_left  = '0;
          done      = 1'b1;
          trk_phase = PH_ADDR;
        end else begin
          trk_left = trk_left - 9'd1;
        end
      end
      default: begin
        acc = 1'b1;
        if (trk_left <= 9'd1) begin
          // byte count of a multiple write, crc pair still to come
          trk_left  = {1'b0, b} + CRC_BYTES;
          trk_phase = PH_BODY;
        end else begin
          trk_left = trk_left - 9'd1;
        end
      end
    endcase
    if (acc) begin
      r.byte_accepted   = 1'b1;
      r.byte_index      = trk_count;
      r.byte_value      = b;
      r.buffer_overflow = (trk_count >= BUF_DEPTH);
      if (trk_count != COUNT_MAX) trk_count = trk_count + 9'd1;
      trk_crc    = crc16_next(trk_crc, b);
      r.frame_done = done;
      r.crc_ok     = done && (trk_crc == 16'h0000);
    end
    r.function_code = trk_code;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 12);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (byte_reports.size() == 0) begin
        report_mismatch("result with no byte pending", res_if.byte_value, 0);
      end else begin
        want = byte_reports.pop_front();
        if (res_if.byte_accepted !== want.byte_accepted)
          report_mismatch("byte_accepted", res_if.byte_accepted, want.byte_accepted);
        if (res_if.byte_index !== want.byte_index)
          report_mismatch("byte_index", res_if.byte_index, want.byte_index);
        if (res_if.byte_value !== want.byte_value)
          report_mismatch("byte_value", res_if.byte_value, want.byte_value);
        if (res_if.buffer_overflow !== want.buffer_overflow)
          report_mismatch("buffer_overflow", res_if.buffer_overflow, want.buffer_overflow);
        if (res_if.frame_abort !== want.frame_abort)
          report_mismatch("frame_abort", res_if.frame_abort, want.frame_abort);
        if (res_if.frame_done !== want.frame_done)
          report_mismatch("frame_done", res_if.frame_done, want.frame_done);
        if (res_if.crc_ok !== want.crc_ok)
          report_mismatch("crc_ok", res_if.crc_ok, want.crc_ok);
        if (res_if.function_code !== want.function_code)
          report_mismatch("function_code", res_if.function_code, want.function_code);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    res_t predicted;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    predicted = frame_track(b);
    byte_reports.push_back(typed ? want : predicted);
    if (predicted.byte_accepted || predicted.frame_abort) framed_items++;
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    while (byte_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_EXP_ADDR) exp_addr = val;
    else reply_len = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'd0, val}) report_mismatch("register readback", prdata, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame();
    logic [7:0]  fb[$];
    logic [7:0]  code;
    logic [15:0] c;
    int          n;
    int          kind;
    bit          no_crc;
    gaps_on = !quiet && ($urandom_range(0, 3) != 0);
    kind    = $urandom_range(0, 11);
    no_crc  = 1'b0;
    if (kind == 0) begin
      // line noise
      repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      do code = 8'($urandom_range(0, 255));
      while (code inside {FC_READ_HOLD, FC_READ_INPUT, FC_WRITE_ONE, FC_WRITE_MULT});
      fb.push_back(exp_addr);
      fb.push_back(code);
    end else begin
      case ($urandom_range(0, 3))
        0:       code = FC_READ_HOLD;
        1:       code = FC_READ_INPUT;
        2:       code = FC_WRITE_ONE;
        default: code = FC_WRITE_MULT;
      endcase
      fb.push_back(exp_addr);
      fb.push_back(code);
      if (code == FC_WRITE_ONE) begin
        n = WRITE_ONE_LEN - CRC_BYTES;
      end else if (code == FC_WRITE_MULT) begin
        repeat (WRITE_HDR_LEN - 1) fb.push_back(8'($urandom_range(0, 255)));
        n = ($urandom_range(0, 59) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 10);
        fb.push_back(8'(n));
      end else if (reply_len < CRC_BYTES) begin
        // a length of zero or one leaves room for a single byte
        n      = 1;
        no_crc = 1'b1;
      end else begin
        n = reply_len - CRC_BYTES;
      end
      repeat (n) fb.push_back(8'($urandom_range(0, 255)));
      if (!no_crc) begin
        c = CRC_INIT;
        foreach (fb[i]) c = crc16_next(c, fb[i]);
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
      end
      case ($urandom_range(0, 15))
        0: fb[$urandom_range(2, fb.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        1: repeat ($urandom_range(1, fb.size() - 2)) void'(fb.pop_back());
        default: ;
      endcase
    end
    foreach (fb[i]) send_byte(fb[i], 1'b0, '0);
  endtask

  initial begin
    dir_row_t   rows [23];
    int         phase_len [5];
    int         target;
    logic [7:0] a;
    logic [7:0] l;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    phase_len     = '{300, 300, 200, 550, 550};
    rows = '{
      '{8'h00,         1'b1, plain_result(1'b0, 9'd0, 8'h00, 1'b0, 8'h00)},
      '{ADDR_RESET,    1'b1, plain_result(1'b1, 9'd0, ADDR_RESET, 1'b0, 8'h00)},
      '{8'hFF,         1'b1, plain_result(1'b0, 9'd0, 8'h00, 1'b1, 8'hFF)},
      '{ADDR_RESET,    1'b1, plain_result(1'b1, 9'd0, ADDR_RESET, 1'b0, 8'h00)},
      '{FC_WRITE_ONE,  1'b1, plain_result(1'b1, 9'd1, FC_WRITE_ONE, 1'b0, FC_WRITE_ONE)},
      '{8'h00,         1'b0, '0},
      '{8'hFF,         1'b0, '0},
      '{8'h80,         1'b0, '0},
      '{8'h01,         1'b0, '0},
      '{8'h55,         1'b0, '0},
      '{8'hAA,         1'b0, '0},
      '{ADDR_RESET,    1'b1, plain_result(1'b1, 9'd0, ADDR_RESET, 1'b0, 8'h00)},
      '{FC_WRITE_MULT, 1'b1, plain_result(1'b1, 9'd1, FC_WRITE_MULT, 1'b0, FC_WRITE_MULT)},
      '{8'h7F,         1'b0, '0},
      '{8'h80,         1'b0, '0},
      '{8'h00,         1'b0, '0},
      '{8'hFF,         1'b0, '0},
      '{8'h00,         1'b0, '0},
      '{8'h12,         1'b0, '0},
      '{8'h34,         1'b0, '0},
      '{ADDR_RESET,    1'b1, plain_result(1'b1, 9'd0, ADDR_RESET, 1'b0, 8'h00)},
      '{FC_READ_INPUT, 1'b1, plain_result(1'b1, 9'd1, FC_READ_INPUT, 1'b0, FC_READ_INPUT)},
      '{8'hC3,         1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gaps_on = 1'b1;
    foreach (rows[k]) send_byte(rows[k].rx, rows[k].typed, rows[k].want);

    // read frame still open: new length must not touch it
    wait_drained();
    cfg_write(REG_READ_LEN, 8'd3);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin a = 8'h00; l = 8'd3; end
        1:       begin a = 8'hFF; l = 8'd255; end
        2:       begin a = 8'($urandom_range(0, 255)); l = 8'd0; end
        default: begin a = 8'($urandom_range(0, 255)); l = 8'($urandom_range(3, 24)); end
      endcase
      wait_drained();
      cfg_write(REG_EXP_ADDR, a);
      cfg_write(REG_READ_LEN, l);
      quiet  = (p == 4);
      target = framed_items + phase_len[p];
      while (framed_items < target) send_frame();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (byte_reports.size() != 0)
      report_mismatch("results never returned", 0, byte_reports.size());
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== modbus_rtu_frame_receiver_core.f =====
rtl/core/mrfr_pkg.sv
rtl/core/mrfr_byte_if.sv
rtl/core/mrfr_res_if.sv
rtl/core/mrfr_cfg_regs.sv
rtl/core/mrfr_in_stage.sv
rtl/core/mrfr_framer.sv
rtl/core/modbus_rtu_frame_receiver_core.sv
sim/modbus_rtu_frame_receiver_core_tb.sv
